// ===== rtl/core/tcde_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and the emission program for the cell delta encoder
package tcde_pkg;

  localparam int MaxColumnsDef = 512;
  localparam int MaxRowsDef    = 256;

  localparam int InDataW  = 72;
  localparam int InUserW  = 3;
  localparam int OutDataW = 8;
  localparam int PairW    = 48;
  localparam int EntryW   = PairW + 1;
  localparam int PcW      = 6;
  localparam int NumW     = 10;

  localparam logic [PcW-1:0] PcLast = PcW'(58);

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_READ,
    ST_RUN,
    ST_LOAD,
    ST_DIG
  } state_t;

  typedef enum logic [2:0] {
    G_CLR,
    G_CUR,
    G_TC,
    G_CB,
    G_COL,
    G_GLY
  } grp_t;

  typedef enum logic [3:0] {
    NUM_ROW,
    NUM_COL,
    NUM_TR,
    NUM_TG,
    NUM_TB,
    NUM_BR,
    NUM_BG,
    NUM_BB,
    NUM_TCUBE,
    NUM_BCUBE
  } num_sel_t;

  typedef struct packed {
    grp_t       grp;
    logic       is_num;
    num_sel_t   num;
    logic [7:0] lit;
    logic       tail_cell;
    logic       tail_clr;
  } tok_t;

  typedef struct packed {
    logic       accept;
    logic       decide;
    logic       wipe;
    logic       load;
    num_sel_t   num;
    logic       emit;
    logic       src_dig;
    logic [7:0] lit;
    logic [1:0] didx;
    logic       last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic wipe_done;
    logic out_free;
    logic en_clr;
    logic en_cur;
    logic en_tc;
    logic en_cb;
    logic en_col;
    logic en_gly;
    logic skip0;
    logic skip1;
  } dp_stat_t;

  localparam logic [7:0] ChEsc  = 8'h1B;
  localparam logic [7:0] ChLbr  = 8'h5B;
  localparam logic [7:0] ChSemi = 8'h3B;

  function automatic tok_t lit_tok(grp_t g, logic [7:0] b);
    tok_t t;
    t = '{grp: g, is_num: 1'b0, num: NUM_ROW, lit: b, tail_cell: 1'b0, tail_clr: 1'b0};
    return t;
  endfunction

  function automatic tok_t num_tok(grp_t g, num_sel_t n);
    tok_t t;
    t = '{grp: g, is_num: 1'b1, num: n, lit: 8'h00, tail_cell: 1'b0, tail_clr: 1'b0};
    return t;
  endfunction

  // emission program: clear, cursor move, truecolor, cube, colour end, glyph
  function automatic tok_t prog_tok(logic [PcW-1:0] pc);
    tok_t t;
    case (pc)
      6'd0:  t = lit_tok(G_CLR, ChEsc);
      6'd1:  t = lit_tok(G_CLR, ChLbr);
      6'd2:  t = lit_tok(G_CLR, "0");
      6'd3:  t = lit_tok(G_CLR, "m");
      6'd4:  t = lit_tok(G_CLR, ChEsc);
      6'd5:  t = lit_tok(G_CLR, ChLbr);
      6'd6:  t = lit_tok(G_CLR, "2");
      6'd7:  t = lit_tok(G_CLR, "J");
      6'd8:  t = lit_tok(G_CLR, ChEsc);
      6'd9:  t = lit_tok(G_CLR, ChLbr);
      6'd10: begin
        t = lit_tok(G_CLR, "H");
        t.tail_clr = 1'b1;
      end
      6'd11: t = lit_tok(G_CUR, ChEsc);
      6'd12: t = lit_tok(G_CUR, ChLbr);
      6'd13: t = num_tok(G_CUR, NUM_ROW);
      6'd14: t = lit_tok(G_CUR, ChSemi);
      6'd15: t = num_tok(G_CUR, NUM_COL);
      6'd16: t = lit_tok(G_CUR, "H");
      6'd17: t = lit_tok(G_TC, ChEsc);
      6'd18: t = lit_tok(G_TC, ChLbr);
      6'd19: t = lit_tok(G_TC, "3");
      6'd20: t = lit_tok(G_TC, "8");
      6'd21: t = lit_tok(G_TC, ChSemi);
      6'd22: t = lit_tok(G_TC, "2");
      6'd23: t = lit_tok(G_TC, ChSemi);
      6'd24: t = num_tok(G_TC, NUM_TR);
      6'd25: t = lit_tok(G_TC, ChSemi);
      6'd26: t = num_tok(G_TC, NUM_TG);
      6'd27: t = lit_tok(G_TC, ChSemi);
      6'd28: t = num_tok(G_TC, NUM_TB);
      6'd29: t = lit_tok(G_TC, ChSemi);
      6'd30: t = lit_tok(G_TC, "4");
      6'd31: t = lit_tok(G_TC, "8");
      6'd32: t = lit_tok(G_TC, ChSemi);
      6'd33: t = lit_tok(G_TC, "2");
      6'd34: t = lit_tok(G_TC, ChSemi);
      6'd35: t = num_tok(G_TC, NUM_BR);
      6'd36: t = lit_tok(G_TC, ChSemi);
      6'd37: t = num_tok(G_TC, NUM_BG);
      6'd38: t = lit_tok(G_TC, ChSemi);
      6'd39: t = num_tok(G_TC, NUM_BB);
      6'd40: t = lit_tok(G_CB, ChEsc);
      6'd41: t = lit_tok(G_CB, ChLbr);
      6'd42: t = lit_tok(G_CB, "3");
      6'd43: t = lit_tok(G_CB, "8");
      6'd44: t = lit_tok(G_CB, ChSemi);
      6'd45: t = lit_tok(G_CB, "5");
      6'd46: t = lit_tok(G_CB, ChSemi);
      6'd47: t = num_tok(G_CB, NUM_TCUBE);
      6'd48: t = lit_tok(G_CB, ChSemi);
      6'd49: t = lit_tok(G_CB, "4");
      6'd50: t = lit_tok(G_CB, "8");
      6'd51: t = lit_tok(G_CB, ChSemi);
      6'd52: t = lit_tok(G_CB, "5");
      6'd53: t = lit_tok(G_CB, ChSemi);
      6'd54: t = num_tok(G_CB, NUM_BCUBE);
      6'd55: t = lit_tok(G_COL, "m");
      6'd56: t = lit_tok(G_GLY, 8'hE2);
      6'd57: t = lit_tok(G_GLY, 8'h96);
      6'd58: begin
        t = lit_tok(G_GLY, 8'h80);
        t.tail_cell = 1'b1;
      end
      default: t = lit_tok(G_GLY, 8'h00);
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/core/terminal_cell_delta_encoder.sv =====
`timescale 1ns / 1ps
// top level of the terminal cell delta encoder: ports, field packing, checks
// first byte: loaded after the READ decision state, once the walk has stepped over every
//   skipped program slot ahead of it, so it comes sooner when a clear leads
// flow: one cell at a time; the walk steps one program slot per cycle, skipped or emitted,
//   an emitted byte waiting for a free output register, plus load and digit states per number
// reset: synchronous active-low; afterwards the shadow memory is swept to invalid, every one
//   of its MAX_ROWS * MAX_COLUMNS entries (131072 by default), with in_tready low
module terminal_cell_delta_encoder #(
  parameter int MAX_COLUMNS = tcde_pkg::MaxColumnsDef,
  parameter int MAX_ROWS    = tcde_pkg::MaxRowsDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // cell transaction
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // top_pixel[23:0], bottom_pixel[47:24], cell_row[55:48], cell_column[64:56], zero pad
  input  logic [tcde_pkg::InDataW-1:0] in_tdata,
  // frame_start[0], clear_screen[1], force_emit[2]
  input  logic [tcde_pkg::InUserW-1:0] in_tuser,
  // byte stream, one byte per transaction at most per cycle; stalls on out_tready
  // stretch the walk
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // out_byte[7:0]
  output logic [tcde_pkg::OutDataW-1:0] out_tdata,
  output logic                         out_tlast,
  // truecolor_mode write
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_data
);
  import tcde_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  st;

  // config is always taken; each cell uses the setting held when it is decided
  assign cfg_ready = 1'b1;

  tcde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  tcde_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .top_pixel    (in_tdata[23:0]),
    .bottom_pixel (in_tdata[47:24]),
    .cell_row     (in_tdata[55:48]),
    .cell_column  (in_tdata[64:56]),
    .frame_start  (in_tuser[0]),
    .clear_screen (in_tuser[1]),
    .force_emit   (in_tuser[2]),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .out_byte     (out_tdata),
    .last_byte    (out_tlast),
    .cmd          (cmd),
    .st           (st)
  );

  // one cell in flight: an accepted transaction closes the input
  a_one_cell: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a cell is in flight");

  // no cell taken while the shadow sweep runs
  a_wipe_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wipe |-> !in_tready)
    else $error("input ready during shadow sweep");

  // a byte is only loaded into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> st.out_free)
    else $error("byte overwrote a pending output");

endmodule

// ===== rtl/core/tcde_ctrl.sv =====
`timescale 1ns / 1ps
// controller: walks the emission program and sequences decimal digits
module tcde_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  tcde_pkg::dp_stat_t  st,
  output tcde_pkg::ctrl_cmd_t cmd
);
  import tcde_pkg::*;

  state_t         state_r, state_nxt;
  logic [PcW-1:0] pc_r, pc_nxt;
  logic [1:0]     didx_r, didx_nxt;
  tok_t           tok;
  logic           en;
  logic           last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_WIPE;
      pc_r    <= '0;
      didx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      didx_r  <= didx_nxt;
    end
  end

  always_comb begin
    tok = prog_tok(pc_r);
    case (tok.grp)
      G_CLR:   en = st.en_clr;
      G_CUR:   en = st.en_cur;
      G_TC:    en = st.en_tc;
      G_CB:    en = st.en_cb;
      G_COL:   en = st.en_col;
      G_GLY:   en = st.en_gly;
      default: en = 1'b0;
    endcase
    last = (tok.tail_cell && st.en_gly) || (tok.tail_clr && !st.en_gly);
  end

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    didx_nxt  = didx_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.num   = tok.num;
    cmd.lit   = tok.lit;
    cmd.didx  = didx_r;
    cmd.last  = last;
    case (state_r)
      ST_WIPE: begin
        cmd.wipe = 1'b1;
        if (st.wipe_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_READ;
        end
      end
      ST_READ: begin
        cmd.decide = 1'b1;
        pc_nxt     = '0;
        state_nxt  = ST_RUN;
      end
      ST_RUN: begin
        if (!en) begin
          if (pc_r == PcLast) state_nxt = ST_IDLE;
          else pc_nxt = pc_r + 1'b1;
        end else if (tok.is_num) begin
          state_nxt = ST_LOAD;
        end else if (st.out_free) begin
          cmd.emit = 1'b1;
          if (pc_r == PcLast) state_nxt = ST_IDLE;
          else pc_nxt = pc_r + 1'b1;
        end
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        didx_nxt  = '0;
        state_nxt = ST_DIG;
      end
      ST_DIG: begin
        // leading zeros are stepped over without a byte
        if ((didx_r == 2'd0 && st.skip0) || (didx_r == 2'd1 && st.skip1)) begin
          didx_nxt = didx_r + 1'b1;
        end else if (st.out_free) begin
          cmd.emit    = 1'b1;
          cmd.src_dig = 1'b1;
          cmd.last    = 1'b0;
          if (didx_r == 2'd2) begin
            pc_nxt    = pc_r + 1'b1;
            state_nxt = ST_RUN;
          end else begin
            didx_nxt = didx_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_WIPE;
    endcase
  end

endmodule

// ===== rtl/core/tcde_dp.sv =====
`timescale 1ns / 1ps
// datapath: shadow memory, cursor and colour state, digit split, output register
module tcde_dp #(
  parameter int MAX_COLUMNS = tcde_pkg::MaxColumnsDef,
  parameter int MAX_ROWS    = tcde_pkg::MaxRowsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [23:0]         top_pixel,
  input  logic [23:0]         bottom_pixel,
  input  logic [7:0]          cell_row,
  input  logic [8:0]          cell_column,
  input  logic                frame_start,
  input  logic                clear_screen,
  input  logic                force_emit,
  input  logic                cfg_valid,
  input  logic                cfg_data,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic [7:0]          out_byte,
  output logic                last_byte,
  input  tcde_pkg::ctrl_cmd_t cmd,
  output tcde_pkg::dp_stat_t  st
);
  import tcde_pkg::*;

  localparam int Depth = MAX_ROWS * MAX_COLUMNS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [EntryW-1:0] mem [Depth];
  logic [EntryW-1:0] rd_r;
  logic [AddrW-1:0]  wcnt_r;
  logic [AddrW-1:0]  addr_r;
  logic [AddrW-1:0]  rd_addr;
  logic              in_range;
  logic              we;
  logic [AddrW-1:0]  wa;
  logic [EntryW-1:0] wd;

  // latched item
  logic [23:0] top_r, bot_r;
  logic [8:0]  row1_r;
  logic [9:0]  col1_r;
  logic        fs_r, clr_r, force_r, range_r;

  // run state
  logic [8:0]       row_next_r;
  logic [9:0]       col_next_r;
  logic             cur_known_r;
  logic [PairW-1:0] last_pair_r;
  logic             col_known_r;
  logic             tc_r;

  // per item decision
  logic       cell_r, cur_need_r, col_need_r, clr_en_r, tc_item_r;
  logic [7:0] tcube_r, bcube_r;

  logic [PairW-1:0] pair;
  logic             cur_k, col_k, hit, paint, cur_need, col_need;

  // digit split
  logic [NumW-1:0] num;
  logic [3:0]      h, h_r, t, u;
  logic [6:0]      r1, r1_r;
  logic [7:0]      dig_byte;

  logic       out_valid_r, out_last_r;
  logic [7:0] out_byte_r;

  function automatic logic [2:0] level6(logic [7:0] c);
    logic [2:0] l;
    if (c < 8'd48)       l = 3'd0;
    else if (c < 8'd115) l = 3'd1;
    else if (c < 8'd155) l = 3'd2;
    else if (c < 8'd195) l = 3'd3;
    else if (c < 8'd235) l = 3'd4;
    else                 l = 3'd5;
    return l;
  endfunction

  function automatic logic [7:0] cube(logic [23:0] rgb);
    logic [7:0] r, g, b;
    r = {5'd0, level6(rgb[23:16])};
    g = {5'd0, level6(rgb[15:8])};
    b = {5'd0, level6(rgb[7:0])};
    return 8'd16 + 8'd36 * r + 8'd6 * g + b;
  endfunction

  assign in_range = (32'(cell_row) < MAX_ROWS) && (32'(cell_column) < MAX_COLUMNS);
  assign rd_addr  = AddrW'(32'(cell_row) * MAX_COLUMNS + 32'(cell_column));

  assign pair     = {top_r, bot_r};
  assign cur_k    = cur_known_r && !fs_r && !clr_r;
  assign col_k    = col_known_r && !fs_r && !clr_r;
  assign hit      = rd_r[EntryW-1] && (rd_r[PairW-1:0] == pair) && !force_r;
  assign paint    = range_r && !hit;
  assign cur_need = !cur_k || (row_next_r != row1_r) || (col_next_r != col1_r);
  assign col_need = !col_k || (last_pair_r != pair);

  assign we = cmd.wipe || (cmd.decide && paint);
  assign wa = cmd.wipe ? wcnt_r : addr_r;
  assign wd = cmd.wipe ? '0 : {1'b1, pair};

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (cmd.accept) rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) wcnt_r <= '0;
    else if (cmd.wipe) wcnt_r <= wcnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      top_r   <= top_pixel;
      bot_r   <= bottom_pixel;
      row1_r  <= {1'b0, cell_row} + 9'd1;
      col1_r  <= {1'b0, cell_column} + 10'd1;
      addr_r  <= rd_addr;
      fs_r    <= frame_start;
      clr_r   <= clear_screen;
      force_r <= force_emit;
      range_r <= in_range;
    end
    if (cmd.decide) begin
      tcube_r <= cube(top_r);
      bcube_r <= cube(bot_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_next_r  <= '0;
      col_next_r  <= '0;
      cur_known_r <= 1'b0;
      last_pair_r <= '0;
      col_known_r <= 1'b0;
      tc_r        <= 1'b0;
      cell_r      <= 1'b0;
      cur_need_r  <= 1'b0;
      col_need_r  <= 1'b0;
      clr_en_r    <= 1'b0;
      tc_item_r   <= 1'b0;
    end else begin
      if (cfg_valid) tc_r <= cfg_data;
      if (cmd.accept) begin
        cell_r   <= 1'b0;
        clr_en_r <= 1'b0;
      end
      if (cmd.decide) begin
        cell_r      <= paint;
        cur_need_r  <= cur_need;
        col_need_r  <= col_need;
        clr_en_r    <= clr_r;
        tc_item_r   <= tc_r;
        cur_known_r <= cur_k || paint;
        col_known_r <= col_k || paint;
        if (paint) begin
          if (cur_need) begin
            row_next_r <= row1_r;
            col_next_r <= col1_r + 10'd1;
          end else begin
            col_next_r <= col_next_r + 10'd1;
          end
          if (col_need) last_pair_r <= pair;
        end
      end
    end
  end

  always_comb begin
    case (cmd.num)
      NUM_ROW:   num = {1'b0, row1_r};
      NUM_COL:   num = col1_r;
      NUM_TR:    num = {2'b0, top_r[23:16]};
      NUM_TG:    num = {2'b0, top_r[15:8]};
      NUM_TB:    num = {2'b0, top_r[7:0]};
      NUM_BR:    num = {2'b0, bot_r[23:16]};
      NUM_BG:    num = {2'b0, bot_r[15:8]};
      NUM_BB:    num = {2'b0, bot_r[7:0]};
      NUM_TCUBE: num = {2'b0, tcube_r};
      NUM_BCUBE: num = {2'b0, bcube_r};
      default:   num = '0;
    endcase
    h = '0;
    for (int k = 1; k <= 9; k++) begin
      if (num >= NumW'(100 * k)) h = 4'(k);
    end
    r1 = 7'(num - NumW'(h) * NumW'(100));
    t = '0;
    for (int k = 1; k <= 9; k++) begin
      if (r1_r >= 7'(10 * k)) t = 4'(k);
    end
    u = 4'(r1_r - 7'(t) * 7'd10);
    case (cmd.didx)
      2'd0:    dig_byte = 8'h30 + {4'd0, h_r};
      2'd1:    dig_byte = 8'h30 + {4'd0, t};
      default: dig_byte = 8'h30 + {4'd0, u};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      h_r  <= h;
      r1_r <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r <= cmd.src_dig ? dig_byte : cmd.lit;
      out_last_r <= cmd.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_byte   = out_byte_r;
  assign last_byte  = out_last_r;

  always_comb begin
    st.wipe_done = (wcnt_r == AddrW'(Depth - 1));
    st.out_free  = !out_valid_r || out_tready;
    st.en_clr    = clr_en_r;
    st.en_cur    = cell_r && cur_need_r;
    st.en_tc     = cell_r && col_need_r && tc_item_r;
    st.en_cb     = cell_r && col_need_r && !tc_item_r;
    st.en_col    = cell_r && col_need_r;
    st.en_gly    = cell_r;
    st.skip0     = (h_r == 4'd0);
    st.skip1     = (h_r == 4'd0) && (t == 4'd0);
  end

endmodule

// ===== verif/terminal_cell_delta_encoder_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the terminal cell delta encoder: directed table, then random cells
module terminal_cell_delta_encoder_tb;
  import tcde_pkg::*;

  localparam int CycleLimit  = 1_500_000;
  localparam int SettleWait  = 200;  // one full program walk with number expansion, with margin
  localparam int RandomCells = 110;  // per random phase

  typedef struct {
    bit          mode;    // truecolor setting this row runs under
    logic [23:0] top;
    logic [23:0] bot;
    logic [7:0]  row;
    logic [8:0]  col;
    bit          fs;
    bit          clr;
    bit          frc;
    bit          typed;   // expected bytes given below instead of predicted
    string       bytes;
  } cell_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } esc_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  // predictor state
  logic [48:0] shadow_mem [bit [16:0]];
  int          cur_row_next;
  int          cur_col_next;
  bit          cur_known;
  logic [47:0] colour_pair;
  bit          colour_known;
  bit          tc_mode;

  esc_byte_t   pending_bytes[$];
  cell_t       dir_tab[$];
  int          errors = 0;
  int          cells_sent = 0;
  int          bytes_seen = 0;
  int          cycles = 0;
  int          tx_idle_pct = 7;
  int          rx_idle_pct = 56;
  bit          rx_hold = 1'b0;

  terminal_cell_delta_encoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("terminal_cell_delta_encoder_tb: done, errors");
      $finish;
    end
  end

  // receiver: random back-pressure, plus a long hold-off from its own process
  always @(posedge clk) begin
    out_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  initial begin
    wait (cells_sent >= 60);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (700) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // output checker: every byte transaction against the oldest expectation
  always @(posedge clk) begin
    esc_byte_t e;
    if (rst_n && out_tvalid && out_tready) begin
      bytes_seen++;
      if (pending_bytes.size() == 0) begin
        $error("unexpected byte: out_byte actual %h", out_tdata);
        errors++;
      end else begin
        e = pending_bytes.pop_front();
        if (out_tdata !== e.data) begin
          $error("out_byte mismatch: expected %h actual %h", e.data, out_tdata);
          errors++;
        end
        if (out_tlast !== e.last) begin
          $error("last_byte mismatch: expected %b actual %b", e.last, out_tlast);
          errors++;
        end
      end
    end
  end

  function automatic int cube_level(int c);
    if (c < 48) return 0;
    if (c < 115) return 1;
    if (c < 155) return 2;
    if (c < 195) return 3;
    if (c < 235) return 4;
    return 5;
  endfunction

  function automatic int cube_of(logic [23:0] rgb);
    return 16 + 36 * cube_level(rgb[23:16]) + 6 * cube_level(rgb[15:8]) + cube_level(rgb[7:0]);
  endfunction

  // expected escape stream for one cell, updating the predictor state
  task automatic encode_cell(input cell_t c);
    string       s;
    logic [47:0] pair;
    logic [48:0] entry;
    esc_byte_t   b;
    int          n;
    s = "";
    pair = {c.top, c.bot};
    entry = {1'b1, pair};
    if (c.fs) begin
      cur_known = 0;
      colour_known = 0;
    end
    if (c.clr) begin
      s = {s, "\033[0m\033[2J\033[H"};
      cur_known = 0;
      colour_known = 0;
    end
    // rows and columns are always in range at the default sizes
    if (c.frc || !shadow_mem.exists({c.row, c.col}) || shadow_mem[{c.row, c.col}] != entry) begin
      shadow_mem[{c.row, c.col}] = entry;
      if (!cur_known || cur_row_next != c.row + 1 || cur_col_next != c.col + 1) begin
        s = {s, $sformatf("\033[%0d;%0dH", c.row + 1, c.col + 1)};
        cur_row_next = c.row + 1;
        cur_col_next = c.col + 1;
        cur_known = 1;
      end
      if (!colour_known || colour_pair != pair) begin
        if (tc_mode)
          s = {s, $sformatf("\033[38;2;%0d;%0d;%0d;48;2;%0d;%0d;%0dm",
                            c.top[23:16], c.top[15:8], c.top[7:0],
                            c.bot[23:16], c.bot[15:8], c.bot[7:0])};
        else
          s = {s, $sformatf("\033[38;5;%0d;48;5;%0dm", cube_of(c.top), cube_of(c.bot))};
        colour_pair = pair;
        colour_known = 1;
      end
      s = {s, "\342\226\200"};
      cur_col_next = (cur_col_next + 1) & 10'h3FF;
    end
    if (c.typed) s = c.bytes;
    n = s.len();
    for (int i = 0; i < n; i++) begin
      b.data = s[i];
      b.last = (i == n - 1);
      pending_bytes.push_back(b);
    end
  endtask

  task automatic send_cell(input cell_t c);
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, c.col, c.row, c.bot, c.top};
    in_tuser  <= {c.frc, c.clr, c.fs};
    do @(posedge clk); while (!in_tready);
    encode_cell(c);
    cells_sent++;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
  endtask

  // wait until nothing is expected and the block has finished any silent cell
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_bytes.size() != 0);
    repeat (SettleWait) @(posedge clk);
  endtask

  task automatic write_mode(input bit m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tc_mode = m;
  endtask

  function automatic cell_t mk(bit m, logic [23:0] t, logic [23:0] bt, int r, int cl,
                               bit fs, bit clr, bit frc, bit typed = 0, string e = "");
    cell_t c;
    c = '{m, t, bt, r[7:0], cl[8:0], fs, clr, frc, typed, e};
    return c;
  endfunction

  // random cell: mostly scans of a small window with a small palette so that
  // follow-on glyphs, repeated colours and shadow hits happen often
  logic [23:0] palette [4];
  int          scan_row = 0;
  int          scan_col = 0;

  function automatic logic [23:0] pick_pixel();
    if ($urandom_range(0, 3) == 0) return 24'($urandom);
    return palette[$urandom_range(0, 3)];
  endfunction

  function automatic cell_t rand_cell(bit m);
    cell_t c;
    int    r, cl;
    if ($urandom_range(0, 9) == 0) begin
      r = $urandom_range(0, 255);
      cl = $urandom_range(0, 511);
    end else begin
      if ($urandom_range(0, 4) == 0) begin
        scan_row = $urandom_range(0, 3);
        scan_col = $urandom_range(0, 7);
      end
      r = scan_row;
      cl = scan_col;
      scan_col = (scan_col + 1) % 10;
      if (scan_col == 0) scan_row = (scan_row + 1) % 4;
    end
    c = mk(m, pick_pixel(), pick_pixel(), r, cl,
           $urandom_range(0, 9) == 0, $urandom_range(0, 19) == 0, $urandom_range(0, 9) == 0);
    return c;
  endfunction

  initial begin
    bit m;
    // directed table: reset, extremes, bucket edges, follow-on, frame and clear handling
    dir_tab.push_back(mk(0, 24'h000000, 24'h000000, 0, 0, 0, 0, 0, 1,
                         "\033[1;1H\033[38;5;16;48;5;16m\342\226\200"));
    dir_tab.push_back(mk(0, 24'h000000, 24'h000000, 0, 0, 0, 0, 0, 1, ""));
    dir_tab.push_back(mk(0, 24'h000000, 24'h000000, 0, 0, 0, 1, 0, 1, "\033[0m\033[2J\033[H"));
    dir_tab.push_back(mk(0, 24'h000000, 24'h000000, 0, 0, 0, 0, 1));
    dir_tab.push_back(mk(0, 24'hFFFFFF, 24'hFFFFFF, 255, 511, 1, 0, 0, 1,
                         "\033[256;512H\033[38;5;231;48;5;231m\342\226\200"));
    dir_tab.push_back(mk(0, 24'h2F3073, 24'h7274C2, 10, 5, 0, 0, 0));
    dir_tab.push_back(mk(0, 24'h2F3073, 24'h7274C2, 10, 6, 0, 0, 0));
    dir_tab.push_back(mk(0, 24'h9A9BC3, 24'hEAEB2F, 10, 7, 0, 0, 0));
    dir_tab.push_back(mk(0, 24'h9A9BC3, 24'hEAEB2F, 10, 8, 1, 0, 0));
    dir_tab.push_back(mk(0, 24'h123456, 24'h654321, 10, 9, 0, 1, 1));
    dir_tab.push_back(mk(0, 24'hAAAAAA, 24'h555555, 170, 341, 1, 1, 1));
    dir_tab.push_back(mk(0, 24'h555555, 24'hAAAAAA, 85, 170, 0, 0, 0));
    dir_tab.push_back(mk(1, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 0, 0, 0, 1,
                         "\033[1;1H\033[38;2;255;255;255;48;2;255;255;255m\342\226\200"));
    dir_tab.push_back(mk(1, 24'h000000, 24'h000000, 0, 1, 0, 0, 0, 1,
                         "\033[38;2;0;0;0;48;2;0;0;0m\342\226\200"));
    dir_tab.push_back(mk(1, 24'h000000, 24'h000000, 0, 2, 0, 0, 0, 1, "\342\226\200"));
    dir_tab.push_back(mk(1, 24'h0A6309, 24'hC8640B, 0, 510, 0, 0, 0));
    dir_tab.push_back(mk(1, 24'h0A6309, 24'hC8640B, 0, 511, 1, 1, 0));
    dir_tab.push_back(mk(1, 24'h0A6309, 24'hC8640B, 0, 511, 0, 0, 0, 1, ""));
    palette = '{24'h000000, 24'hFFFFFF, 24'h3080C0, 24'hC08030};

    cur_row_next = 0;
    cur_col_next = 0;
    cur_known = 0;
    colour_pair = '0;
    colour_known = 0;
    tc_mode = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    write_mode(0);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].mode != tc_mode) begin
        drain();
        write_mode(dir_tab[i].mode);
      end
      send_cell(dir_tab[i]);
    end

    // random phases: sender dense and receiver slow, then swapped, then no idling
    for (int p = 0; p < 3; p++) begin
      drain();
      tx_idle_pct = (p == 0) ? 7 : (p == 1) ? 56 : 0;
      rx_idle_pct = (p == 0) ? 56 : (p == 1) ? 7 : 0;
      m = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : 1'($urandom);
      write_mode(m);
      for (int k = 0; k < RandomCells; k++) send_cell(rand_cell(m));
    end
    drain();

    $display("covered %0d cells in both colour modes, %0d stream bytes checked",
             cells_sent, bytes_seen);
    if (errors == 0) begin
      $display("terminal_cell_delta_encoder_tb: done, clean");
    end else begin
      $display("terminal_cell_delta_encoder_tb: done, errors");
    end
    $finish;
  end

endmodule
